@@ hdl/dq_pkg.sv @@
// ----------------------------------------------------------------------------
// dq_pkg
// Types and constants shared by the double-ended queue and its test bench.
// ----------------------------------------------------------------------------
`default_nettype none

package dq_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int WORD_W = 32;

  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_PEEK_FRONT = 3'd4;
  localparam logic [2:0] OP_PEEK_BACK  = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]               operation;
    logic signed [WORD_W-1:0] push_value;
  } dq_in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] read_value;
    logic [1:0]               status;
  } dq_out_t;

endpackage

`default_nettype wire

@@ hdl/double_ended_queue.sv @@
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of 32-bit signed words held in a ring buffer RAM.
// ----------------------------------------------------------------------------
// A request beat is taken when start is high and busy is low; busy is never
// raised, so one request may be issued every cycle. in_item carries the
// operation and, for pushes, the word to store.
// Every request produces exactly one result beat: out_valid is high for one
// cycle, in the cycle after the request was taken, with out_item holding the
// word popped or peeked (zero otherwise) and the status (ok, empty, full).
// The result word comes from the registered read port of the entry RAM;
// throughput is one request per cycle.
// Front index and count live in registers and are updated when the request
// is taken; a push writes the RAM in that same cycle, so a read issued on the
// next cycle already sees the word.
// Reset (rst_n low, synchronous) empties the queue; RAM contents are left
// as they are and are never read before being written.
// The receiver cannot stall: a result must be taken in the cycle it appears.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  output logic                 busy,
  input  wire dq_pkg::dq_in_t  in_item,
  output logic                 out_valid,
  output dq_pkg::dq_out_t      out_item
);

  logic [dq_pkg::IDX_W-1:0]  front_r, front_nxt;
  logic [dq_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic                      valid_r, valid_nxt;
  logic                      rd_sel_r, rd_sel_nxt;
  logic [1:0]                status_r, status_nxt;

  logic                      accept;
  logic                      is_full, is_empty;
  logic [dq_pkg::IDX_W-1:0]  back_pos, last_pos;
  logic                      wr_en;
  logic [dq_pkg::IDX_W-1:0]  wr_addr;
  logic                      rd_en;
  logic [dq_pkg::IDX_W-1:0]  rd_addr;
  logic [dq_pkg::WORD_W-1:0] rd_data;

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign is_full  = (count_r == dq_pkg::CNT_W'(dq_pkg::DEPTH));
  assign is_empty = (count_r == '0);
  // ring positions wrap through index width (depth is a power of two)
  assign back_pos = front_r + count_r[dq_pkg::IDX_W-1:0];
  assign last_pos = back_pos - dq_pkg::IDX_W'(1);

  always_comb begin
    front_nxt  = front_r;
    count_nxt  = count_r;
    valid_nxt  = accept;
    rd_sel_nxt = 1'b0;
    status_nxt = dq_pkg::ST_OK;
    wr_en      = 1'b0;
    wr_addr    = back_pos;
    rd_en      = 1'b0;
    rd_addr    = front_r;
    if (accept) begin
      case (in_item.operation)
        dq_pkg::OP_PUSH_FRONT: begin
          if (is_full) begin
            status_nxt = dq_pkg::ST_FULL;
          end else begin
            front_nxt = front_r - dq_pkg::IDX_W'(1);
            wr_en     = 1'b1;
            wr_addr   = front_r - dq_pkg::IDX_W'(1);
            count_nxt = count_r + dq_pkg::CNT_W'(1);
          end
        end
        dq_pkg::OP_PUSH_BACK: begin
          if (is_full) begin
            status_nxt = dq_pkg::ST_FULL;
          end else begin
            wr_en     = 1'b1;
            wr_addr   = back_pos;
            count_nxt = count_r + dq_pkg::CNT_W'(1);
          end
        end
        dq_pkg::OP_POP_FRONT, dq_pkg::OP_PEEK_FRONT: begin
          if (is_empty) begin
            status_nxt = dq_pkg::ST_EMPTY;
          end else begin
            rd_en      = 1'b1;
            rd_addr    = front_r;
            rd_sel_nxt = 1'b1;
            if (in_item.operation == dq_pkg::OP_POP_FRONT) begin
              front_nxt = front_r + dq_pkg::IDX_W'(1);
              count_nxt = count_r - dq_pkg::CNT_W'(1);
            end
          end
        end
        dq_pkg::OP_POP_BACK, dq_pkg::OP_PEEK_BACK: begin
          if (is_empty) begin
            status_nxt = dq_pkg::ST_EMPTY;
          end else begin
            rd_en      = 1'b1;
            rd_addr    = last_pos;
            rd_sel_nxt = 1'b1;
            if (in_item.operation == dq_pkg::OP_POP_BACK) begin
              count_nxt = count_r - dq_pkg::CNT_W'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r  <= '0;
      count_r  <= '0;
      valid_r  <= 1'b0;
      rd_sel_r <= 1'b0;
      status_r <= dq_pkg::ST_OK;
    end else begin
      front_r  <= front_nxt;
      count_r  <= count_nxt;
      valid_r  <= valid_nxt;
      rd_sel_r <= rd_sel_nxt;
      status_r <= status_nxt;
    end
  end

  dq_ram #(
    .WIDTH (dq_pkg::WORD_W),
    .DEPTH (dq_pkg::DEPTH)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_item.push_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_valid           = valid_r;
  assign out_item.read_value = rd_sel_r ? rd_data : '0;
  assign out_item.status     = status_r;

endmodule

`default_nettype wire

@@ hdl/dq_ram.sv @@
// ----------------------------------------------------------------------------
// dq_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ bench/double_ended_queue_test.sv @@
// ----------------------------------------------------------------------------
// double_ended_queue_test
// Self-checking bench for the bounded deque: a directed script walks the
// empty, full, wrap and unknown-operation corners, then biased random traffic
// drives the queue between empty and full. Every result beat is compared with
// a cycle-free software deque that runs alongside, or with a pinned script answer.
// ----------------------------------------------------------------------------
module double_ended_queue_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT  = 2000;
  localparam int RANDOM_BEATS = 950;
  localparam int SCRIPT_ROWS  = 24;

  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  typedef struct {
    logic [2:0]                dq_op;
    logic [dq_pkg::WORD_W-1:0] word;
    int                        reps;
    bit                        pinned;
    dq_pkg::dq_out_t           answer;
  } script_row_t;

  localparam dq_pkg::dq_out_t NONE_EMPTY = '{read_value: '0, status: dq_pkg::ST_EMPTY};
  localparam dq_pkg::dq_out_t NONE_FULL  = '{read_value: '0, status: dq_pkg::ST_FULL};
  localparam dq_pkg::dq_out_t NONE_OK    = '{read_value: '0, status: dq_pkg::ST_OK};

  // word is incremented per repetition of a row
  script_row_t script [SCRIPT_ROWS] = '{
    '{dq_pkg::OP_POP_FRONT,  32'h0000_0000, 1,  1'b1, NONE_EMPTY},
    '{dq_pkg::OP_POP_BACK,   32'h0000_0000, 1,  1'b1, NONE_EMPTY},
    '{dq_pkg::OP_PEEK_FRONT, 32'hFFFF_FFFF, 1,  1'b1, NONE_EMPTY},
    '{dq_pkg::OP_PEEK_BACK,  32'h0000_0000, 1,  1'b1, NONE_EMPTY},
    '{OP_SPARE_6,            32'h1234_5678, 1,  1'b1, NONE_OK},
    '{OP_SPARE_7,            32'hFFFF_FFFF, 1,  1'b1, NONE_OK},
    '{dq_pkg::OP_PUSH_BACK,  32'h7FFF_FFFF, 1,  1'b0, NONE_OK},
    '{dq_pkg::OP_PUSH_FRONT, 32'h8000_0000, 1,  1'b0, NONE_OK},
    '{dq_pkg::OP_PEEK_FRONT, 32'h0000_0000, 1,  1'b0, NONE_OK},
    '{dq_pkg::OP_PEEK_BACK,  32'h0000_0000, 1,  1'b0, NONE_OK},
    '{dq_pkg::OP_POP_BACK,   32'h0000_0000, 1,  1'b0, NONE_OK},
    '{dq_pkg::OP_POP_BACK,   32'h0000_0000, 1,  1'b0, NONE_OK},
    '{dq_pkg::OP_POP_BACK,   32'h0000_0000, 1,  1'b1, NONE_EMPTY},
    '{dq_pkg::OP_PUSH_FRONT, 32'hFFFF_FFF0, 8,  1'b0, NONE_OK},
    '{dq_pkg::OP_PUSH_BACK,  32'h0000_0000, 8,  1'b0, NONE_OK},
    '{dq_pkg::OP_PUSH_BACK,  32'h5555_5555, 1,  1'b1, NONE_FULL},
    '{dq_pkg::OP_PUSH_FRONT, 32'hAAAA_AAAA, 1,  1'b1, NONE_FULL},
    '{OP_SPARE_7,            32'h0000_0000, 1,  1'b1, NONE_OK},
    '{dq_pkg::OP_PEEK_BACK,  32'h0000_0000, 1,  1'b0, NONE_OK},
    '{dq_pkg::OP_POP_FRONT,  32'h0000_0000, 16, 1'b0, NONE_OK},
    '{dq_pkg::OP_PEEK_FRONT, 32'h0000_0000, 1,  1'b1, NONE_EMPTY},
    '{dq_pkg::OP_POP_BACK,   32'h0000_0000, 1,  1'b1, NONE_EMPTY},
    '{dq_pkg::OP_PUSH_BACK,  32'h0000_0001, 1,  1'b0, NONE_OK},
    '{dq_pkg::OP_POP_FRONT,  32'h0000_0000, 1,  1'b0, NONE_OK}
  };

  logic            clk        = 1'b0;
  logic            rst_n      = 1'b0;
  logic            start      = 1'b0;
  dq_pkg::dq_in_t  in_item    = '0;
  logic            busy;
  logic            out_valid;
  dq_pkg::dq_out_t out_item;

  bit              pin_en     = 1'b0;
  dq_pkg::dq_out_t pin_answer = '0;

  logic signed [dq_pkg::WORD_W-1:0] ring_words [dq_pkg::DEPTH];
  int      head_slot  = 0;
  int      held_count = 0;

  dq_pkg::dq_out_t answers_due [$];
  int      err_count    = 0;
  int      quiet_cycles = 0;
  int      push_bias    = 50;
  bit      no_idle      = 1'b0;

  double_ended_queue DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic dq_pkg::dq_out_t apply_request(dq_pkg::dq_in_t req);
    dq_pkg::dq_out_t ans;
    int              slot;
    ans.read_value = '0;
    ans.status     = dq_pkg::ST_OK;
    case (req.operation)
      dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_BACK: begin
        if (held_count >= dq_pkg::DEPTH) begin
          ans.status = dq_pkg::ST_FULL;
        end else begin
          if (req.operation == dq_pkg::OP_PUSH_FRONT) begin
            head_slot = (head_slot + dq_pkg::DEPTH - 1) % dq_pkg::DEPTH;
            slot      = head_slot;
          end else begin
            slot = (head_slot + held_count) % dq_pkg::DEPTH;
          end
          ring_words[slot] = req.push_value;
          held_count++;
        end
      end
      dq_pkg::OP_POP_FRONT, dq_pkg::OP_PEEK_FRONT,
      dq_pkg::OP_POP_BACK, dq_pkg::OP_PEEK_BACK: begin
        if (held_count == 0) begin
          ans.status = dq_pkg::ST_EMPTY;
        end else begin
          if (req.operation == dq_pkg::OP_POP_FRONT ||
              req.operation == dq_pkg::OP_PEEK_FRONT)
            slot = head_slot;
          else
            slot = (head_slot + held_count - 1) % dq_pkg::DEPTH;
          ans.read_value = ring_words[slot];
          if (req.operation == dq_pkg::OP_POP_FRONT) begin
            head_slot = (head_slot + 1) % dq_pkg::DEPTH;
            held_count--;
          end else if (req.operation == dq_pkg::OP_POP_BACK) begin
            held_count--;
          end
        end
      end
      default: ;
    endcase
    return ans;
  endfunction

  // prediction on the request beat, comparison on the result beat
  always @(posedge clk) begin
    dq_pkg::dq_out_t want;
    bit              quiet;
    quiet = 1'b1;
    if (rst_n && start && busy === 1'b0) begin
      want = apply_request(in_item);
      if (pin_en)
        want = pin_answer;
      answers_due.push_back(want);
      quiet = 1'b0;
    end
    if (rst_n && out_valid === 1'b1) begin
      quiet = 1'b0;
      if (answers_due.size() == 0) begin
        $error("unexpected result beat: read_value %0d status %0d",
               out_item.read_value, out_item.status);
        err_count++;
      end else begin
        want = answers_due.pop_front();
        if (out_item.read_value !== want.read_value) begin
          $error("read_value: expected %0d, got %0d", want.read_value, out_item.read_value);
          err_count++;
        end
        if (out_item.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_item.status);
          err_count++;
        end
      end
    end
    quiet_cycles = quiet ? quiet_cycles + 1 : 0;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic int pick_gap();
    int roll;
    if (no_idle)
      return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  task automatic send_beat(dq_pkg::dq_in_t beat, bit pinned, dq_pkg::dq_out_t answer);
    start      <= 1'b1;
    in_item    <= beat;
    pin_en     <= pinned;
    pin_answer <= answer;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic pause(int cycles);
    dq_pkg::dq_in_t noise;
    if (cycles > 0) begin
      noise.operation  = 3'($urandom_range(0, 7));
      noise.push_value = $urandom();
      start   <= 1'b0;
      pin_en  <= 1'b0;
      in_item <= noise;
      repeat (cycles) @(posedge clk);
    end
  endtask

  initial begin
    dq_pkg::dq_in_t beat;
    int             roll;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      for (int r = 0; r < script[i].reps; r++) begin
        beat.operation  = script[i].dq_op;
        beat.push_value = script[i].word + r;
        send_beat(beat, script[i].pinned, script[i].answer);
        pause(pick_gap());
      end
    end

    // phases lean toward filling, draining or churning the queue
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       push_bias = 20;
          1:       push_bias = 50;
          default: push_bias = 80;
        endcase
        no_idle = ($urandom_range(0, 3) == 0);
      end
      roll = $urandom_range(0, 99);
      if (roll < 4)
        beat.operation = $urandom_range(0, 1) ? OP_SPARE_7 : OP_SPARE_6;
      else if ($urandom_range(0, 99) < push_bias)
        beat.operation = $urandom_range(0, 1) ? dq_pkg::OP_PUSH_BACK : dq_pkg::OP_PUSH_FRONT;
      else
        beat.operation = 3'($urandom_range(dq_pkg::OP_POP_FRONT, dq_pkg::OP_PEEK_BACK));
      case ($urandom_range(0, 9))
        0:       beat.push_value = 32'h7FFF_FFFF;
        1:       beat.push_value = 32'h8000_0000;
        2:       beat.push_value = '0;
        3:       beat.push_value = '1;
        default: beat.push_value = $urandom();
      endcase
      send_beat(beat, 1'b0, NONE_OK);
      pause(pick_gap());
    end
    start  <= 1'b0;
    pin_en <= 1'b0;

    while (answers_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (err_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ double_ended_queue.f @@
hdl/dq_pkg.sv
hdl/dq_ram.sv
hdl/double_ended_queue.sv
bench/double_ended_queue_test.sv
